// ----- sv/checked_integer_alu_defines.svh -----
// assertion macros for the checked integer alu
`ifndef CHECKED_INTEGER_ALU_DEFINES_SVH
`define CHECKED_INTEGER_ALU_DEFINES_SVH

// same-cycle implication
`define CIA_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define CIA_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) else $error(msg);

`endif

// ----- sv/cia_pkg.sv -----
// shared types and codes for the checked integer alu
package cia_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,
    OP_EQ   = 5'd5,
    OP_NE   = 5'd6,
    OP_GT   = 5'd7,
    OP_GE   = 5'd8,
    OP_LT   = 5'd9,
    OP_LE   = 5'd10,
    OP_LAND = 5'd11,
    OP_LOR  = 5'd12,
    OP_LNOT = 5'd13,
    OP_AND  = 5'd14,
    OP_OR   = 5'd15,
    OP_XOR  = 5'd16,
    OP_NOT  = 5'd17,
    OP_SHL  = 5'd18,
    OP_SHR  = 5'd19
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_DIV0  = 2'd2,
    ST_SHIFT = 2'd3
  } status_t;

  typedef struct packed {
    logic    valid;
    logic    is_div;
    logic    is_mod;
    logic    neg_q;
    logic    neg_r;
    status_t st;
  } ctl_t;

endpackage

// ----- sv/checked_integer_alu.sv -----
// checked integer alu top level: front stage, divider cell chain, output register
//
// usage: drive action, a_operand and b_operand with start high; the item is
// taken at a rising edge where start is high and busy is low. busy is high during
// reset and up to the first edge with reset low; then one item can enter per cycle.
// every item gives one result: result and status appear for exactly one cycle
// with done high, after the item has passed the decode stage, each divider cell and
// the output register. latency is the same for every operation, so results leave
// in the order items came in. the depth is set by the divider: one restoring step
// per cell, DATA_WIDTH cells in a row, plus the decode stage in front and the output
// register. throughput is one item per cycle for all operations.
// reset is synchronous and drops every item in flight; done is low after it.
// the receiver cannot stall: a result not taken in its cycle is gone.
// only the low DATA_WIDTH bits of the operands are used; an error gives
// result 0 with status 1 overflow, 2 divide by zero or 3 shift out of range.
module checked_integer_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  action,
  input  logic signed [31:0] a_operand,
  input  logic signed [31:0] b_operand,
  output logic        done,
  output logic signed [31:0] result,
  output logic [1:0]  status
);

  localparam int DW = DATA_WIDTH;

  logic [DW-1:0] a_w;
  logic [DW-1:0] b_w;

  cia_pkg::ctl_t ctl_c [DW+1];
  logic [DW-1:0] res_c [DW+1];
  logic [DW-1:0] rem_c [DW+1];
  logic [DW-1:0] quo_c [DW+1];
  logic [DW-1:0] dvs_c [DW+1];

  logic [DW-1:0] fin_next;
  cia_pkg::ctl_t last;

  assign a_w = DW'($unsigned(a_operand));
  assign b_w = DW'($unsigned(b_operand));
  assign rem_c[0] = '0;

  cia_front #(.DW(DW)) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start && !busy),
    .action (action),
    .a      (a_w),
    .b      (b_w),
    .ctl    (ctl_c[0]),
    .res    (res_c[0]),
    .quo    (quo_c[0]),
    .dvs    (dvs_c[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    cia_div_cell #(.DW(DW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_c[i]),
      .res_in (res_c[i]),
      .rem_in (rem_c[i]),
      .quo_in (quo_c[i]),
      .dvs_in (dvs_c[i]),
      .ctl    (ctl_c[i+1]),
      .res    (res_c[i+1]),
      .rem    (rem_c[i+1]),
      .quo    (quo_c[i+1]),
      .dvs    (dvs_c[i+1])
    );
  end

  always_comb begin
    last = ctl_c[DW];
    if (last.is_div) begin
      fin_next = last.neg_q ? (~quo_c[DW] + 1'b1) : quo_c[DW];
    end else if (last.is_mod) begin
      fin_next = last.neg_r ? (~rem_c[DW] + 1'b1) : rem_c[DW];
    end else begin
      fin_next = res_c[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      busy <= 1'b1;
    end else begin
      done <= last.valid;
      busy <= 1'b0;
    end
    result <= $signed(32'($unsigned(fin_next)));
    status <= last.st;
  end

endmodule

// ----- sv/cia_front.sv -----
// operand decode, the operations other than divide and modulo, and divider setup
module cia_front #(
  parameter int DW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [4:0]         action,
  input  logic [DW-1:0]      a,
  input  logic [DW-1:0]      b,
  output cia_pkg::ctl_t      ctl,
  output logic [DW-1:0]      res,
  output logic [DW-1:0]      quo,
  output logic [DW-1:0]      dvs
);

  localparam int SW = (DW > 1) ? $clog2(DW) : 1;

  cia_pkg::ctl_t   ctl_next;
  logic [DW-1:0]   res_next;
  logic [DW-1:0]   sum;
  logic [DW-1:0]   dif;
  logic [2*DW-1:0] prod;
  logic [DW-1:0]   mag_a;
  logic [DW-1:0]   mag_b;
  logic            lt_ab;
  logic            lt_ba;
  logic            shift_bad;
  logic [SW-1:0]   sh;
  logic [DW:0]     hi_bits;

  always_comb begin
    sum       = a + b;
    dif       = a - b;
    prod      = $signed(a) * $signed(b);
    hi_bits   = prod[2*DW-1:DW-1];
    mag_a     = a[DW-1] ? (~a + 1'b1) : a;
    mag_b     = b[DW-1] ? (~b + 1'b1) : b;
    lt_ab     = $signed(a) < $signed(b);
    lt_ba     = $signed(b) < $signed(a);
    shift_bad = b[DW-1] || (b >= DW'(DW));
    sh        = b[SW-1:0];
    ctl_next        = '0;
    ctl_next.valid  = start;
    ctl_next.st     = cia_pkg::ST_OK;
    res_next        = '0;
    case (action)
      cia_pkg::OP_ADD: begin
        if ((a[DW-1] ^ sum[DW-1]) & (b[DW-1] ^ sum[DW-1])) ctl_next.st = cia_pkg::ST_OVF;
        else res_next = sum;
      end
      cia_pkg::OP_SUB: begin
        if ((a[DW-1] ^ b[DW-1]) & (a[DW-1] ^ dif[DW-1])) ctl_next.st = cia_pkg::ST_OVF;
        else res_next = dif;
      end
      cia_pkg::OP_MUL: begin
        if (!((&hi_bits) || !(|hi_bits))) ctl_next.st = cia_pkg::ST_OVF;
        else res_next = prod[DW-1:0];
      end
      cia_pkg::OP_DIV, cia_pkg::OP_MOD: begin
        if (b == '0) ctl_next.st = cia_pkg::ST_DIV0;
        else if (a == {1'b1, {(DW-1){1'b0}}} && (&b)) ctl_next.st = cia_pkg::ST_OVF;
        else begin
          ctl_next.is_div = (action == cia_pkg::OP_DIV);
          ctl_next.is_mod = (action == cia_pkg::OP_MOD);
        end
      end
      cia_pkg::OP_EQ:   res_next = DW'(a == b);
      cia_pkg::OP_NE:   res_next = DW'(a != b);
      cia_pkg::OP_GT:   res_next = DW'(lt_ba);
      cia_pkg::OP_GE:   res_next = DW'(!lt_ab);
      cia_pkg::OP_LT:   res_next = DW'(lt_ab);
      cia_pkg::OP_LE:   res_next = DW'(!lt_ba);
      cia_pkg::OP_LAND: res_next = DW'((|a) && (|b));
      cia_pkg::OP_LOR:  res_next = DW'((|a) || (|b));
      cia_pkg::OP_LNOT: res_next = DW'(!(|a));
      cia_pkg::OP_AND:  res_next = a & b;
      cia_pkg::OP_OR:   res_next = a | b;
      cia_pkg::OP_XOR:  res_next = a ^ b;
      cia_pkg::OP_NOT:  res_next = ~a;
      cia_pkg::OP_SHL: begin
        if (shift_bad) ctl_next.st = cia_pkg::ST_SHIFT;
        else res_next = a << sh;
      end
      cia_pkg::OP_SHR: begin
        if (shift_bad) ctl_next.st = cia_pkg::ST_SHIFT;
        else res_next = $unsigned($signed(a) >>> sh);
      end
      default: ctl_next.st = cia_pkg::ST_OVF;
    endcase
    ctl_next.neg_q = a[DW-1] ^ b[DW-1];
    ctl_next.neg_r = a[DW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
    res <= res_next;
    quo <= mag_a;
    dvs <= mag_b;
  end

endmodule

// ----- sv/cia_div_cell.sv -----
// one restoring division step, registered, passing the item to the next cell
module cia_div_cell #(
  parameter int DW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cia_pkg::ctl_t      ctl_in,
  input  logic [DW-1:0]      res_in,
  input  logic [DW-1:0]      rem_in,
  input  logic [DW-1:0]      quo_in,
  input  logic [DW-1:0]      dvs_in,
  output cia_pkg::ctl_t      ctl,
  output logic [DW-1:0]      res,
  output logic [DW-1:0]      rem,
  output logic [DW-1:0]      quo,
  output logic [DW-1:0]      dvs
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;
  logic [DW-1:0] quo_next;

  always_comb begin
    trial    = {rem_in, quo_in[DW-1]};
    diff     = trial - {1'b0, dvs_in};
    ge       = !diff[DW];
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    quo_next = {quo_in[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
    res <= res_in;
    rem <= rem_next;
    quo <= quo_next;
    dvs <= dvs_in;
  end

endmodule

// ----- sv/cia_checker.sv -----
// port-level checks for the checked integer alu, bound to the top level
`include "checked_integer_alu_defines.svh"

module cia_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [31:0] result,
  input logic [1:0]  status
);

  `CIA_ASSERT_NXT(a_busy_low, !rst, !busy, "busy high outside reset")
  `CIA_ASSERT_NXT(a_rst_quiet, rst, !done, "result right after reset")
  `CIA_ASSERT_IMP(a_err_zero, done && (status != cia_pkg::ST_OK), result == 32'd0, "error with nonzero result")

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result),
  .status (status)
);

// ----- verif/checked_integer_alu_tb.sv -----
// self-checking testbench for the checked integer alu: random and corner operations
module checked_integer_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam logic [31:0] MIN_INT = 32'h8000_0000;
  localparam logic [31:0] MAX_INT = 32'h7fff_ffff;
  localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [4:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_item_t;

  typedef struct {
    logic [31:0]      value;
    cia_pkg::status_t st;
  } alu_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        busy_seen = 1'b1;
  logic [4:0]  action = '0;
  logic signed [31:0] a_operand = '0;
  logic signed [31:0] b_operand = '0;
  logic        done;
  logic signed [31:0] result;
  logic [1:0]  status;

  alu_item_t    pending_items[$];
  alu_outcome_t expected_outcomes[$];
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int send_idle_pct = 28;
  bit stim_done = 1'b0;

  checked_integer_alu #(.DATA_WIDTH(W)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .a_operand(a_operand), .b_operand(b_operand), .done(done), .result(result),
    .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic alu_outcome_t compute_alu(alu_item_t it);
    alu_outcome_t o;
    logic signed [31:0] sa, sb;
    logic signed [63:0] wide;
    logic [31:0] s;
    sa = it.a;
    sb = it.b;
    o.value = '0;
    o.st = cia_pkg::ST_OK;
    case (it.op)
      cia_pkg::OP_ADD: begin
        wide = 64'(sa) + 64'(sb);
        if (wide > 64'(signed'(MAX_INT)) || wide < 64'(signed'(MIN_INT))) o.st = cia_pkg::ST_OVF;
        else o.value = wide[31:0];
      end
      cia_pkg::OP_SUB: begin
        wide = 64'(sa) - 64'(sb);
        if (wide > 64'(signed'(MAX_INT)) || wide < 64'(signed'(MIN_INT))) o.st = cia_pkg::ST_OVF;
        else o.value = wide[31:0];
      end
      cia_pkg::OP_MUL: begin
        wide = 64'(sa) * 64'(sb);
        if (wide > 64'(signed'(MAX_INT)) || wide < 64'(signed'(MIN_INT))) o.st = cia_pkg::ST_OVF;
        else o.value = wide[31:0];
      end
      cia_pkg::OP_DIV, cia_pkg::OP_MOD: begin
        if (it.b == 0) o.st = cia_pkg::ST_DIV0;
        else if (it.a == MIN_INT && it.b == MINUS_ONE) o.st = cia_pkg::ST_OVF;
        else if (it.op == cia_pkg::OP_DIV) o.value = 32'(64'(sa) / 64'(sb));
        else o.value = 32'(64'(sa) % 64'(sb));
      end
      cia_pkg::OP_EQ:   o.value = 32'(sa == sb);
      cia_pkg::OP_NE:   o.value = 32'(sa != sb);
      cia_pkg::OP_GT:   o.value = 32'(sa > sb);
      cia_pkg::OP_GE:   o.value = 32'(sa >= sb);
      cia_pkg::OP_LT:   o.value = 32'(sa < sb);
      cia_pkg::OP_LE:   o.value = 32'(sa <= sb);
      cia_pkg::OP_LAND: o.value = 32'(it.a != 0 && it.b != 0);
      cia_pkg::OP_LOR:  o.value = 32'(it.a != 0 || it.b != 0);
      cia_pkg::OP_LNOT: o.value = 32'(it.a == 0);
      cia_pkg::OP_AND:  o.value = it.a & it.b;
      cia_pkg::OP_OR:   o.value = it.a | it.b;
      cia_pkg::OP_XOR:  o.value = it.a ^ it.b;
      cia_pkg::OP_NOT:  o.value = ~it.a;
      cia_pkg::OP_SHL, cia_pkg::OP_SHR: begin
        if (it.b > 31) o.st = cia_pkg::ST_SHIFT;
        else if (it.op == cia_pkg::OP_SHL) o.value = it.a << it.b[4:0];
        else begin
          s = sa >>> it.b[4:0];
          o.value = s;
        end
      end
      default: o.st = cia_pkg::ST_OVF;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic queue_item(logic [4:0] op, logic [31:0] a, logic [31:0] b);
    alu_item_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN_INT;
      1: return MAX_INT;
      2: return MINUS_ONE;
      3: return 32'($urandom_range(0, 2));
      4: return 32'($urandom_range(0, 40));
      5: return 32'(-$urandom_range(0, 40));
      6: return 32'($urandom_range(0, 65535));
      7: return 32'(-$urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  // busy as seen by the last rising edge
  always @(posedge clk) begin
    busy_seen <= busy;
  end

  // driver: item taken on rising edge with start high and busy low
  always @(negedge clk) begin
    alu_item_t it;
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy_seen) begin
      start <= 1'b1;
    end else if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      it = pending_items.pop_front();
      action <= it.op;
      a_operand <= it.a;
      b_operand <= it.b;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    alu_item_t it;
    alu_outcome_t exp_o;
    cycle_count <= cycle_count + 1;
    if (!rst && start && !busy) begin
      it.op = action;
      it.a = a_operand;
      it.b = b_operand;
      expected_outcomes.push_back(compute_alu(it));
      items_sent <= items_sent + 1;
    end
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        exp_o = expected_outcomes.pop_front();
        if (result !== exp_o.value)
          report_mismatch($sformatf("result %h, expected %h", result, exp_o.value));
        if (status !== exp_o.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_o.st));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("checked_integer_alu_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] corners[6];
    corners = '{MIN_INT, MAX_INT, MINUS_ONE, 32'd0, 32'd1, 32'd31};
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed corners
    for (int op = 0; op <= 19; op++) queue_item(5'(op), MAX_INT, 32'd1);
    queue_item(cia_pkg::OP_ADD, MIN_INT, MINUS_ONE);
    queue_item(cia_pkg::OP_SUB, MIN_INT, 32'd1);
    queue_item(cia_pkg::OP_MUL, MIN_INT, MINUS_ONE);
    queue_item(cia_pkg::OP_MUL, MIN_INT, 32'd1);
    queue_item(cia_pkg::OP_DIV, MIN_INT, MINUS_ONE);
    queue_item(cia_pkg::OP_MOD, MIN_INT, MINUS_ONE);
    queue_item(cia_pkg::OP_DIV, 32'd5, 32'd0);
    queue_item(cia_pkg::OP_MOD, 32'(-7), 32'd2);
    queue_item(cia_pkg::OP_SHL, MINUS_ONE, 32'd31);
    queue_item(cia_pkg::OP_SHR, MIN_INT, 32'd31);
    queue_item(cia_pkg::OP_SHR, MIN_INT, 32'd32);
    queue_item(cia_pkg::OP_SHL, 32'd1, MINUS_ONE);
    queue_item(5'd31, 32'd0, 32'd0);
    foreach (corners[i]) foreach (corners[j])
      queue_item(5'($urandom_range(0, 19)), corners[i], corners[j]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 74 : 0;
      for (int n = 0; n < 550; n++) begin
        logic [4:0] op;
        logic [31:0] b;
        op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
                                          : 5'($urandom_range(0, 19));
        b = pick_operand();
        if ((op == cia_pkg::OP_SHL || op == cia_pkg::OP_SHR) && $urandom_range(0, 3) != 0)
          b = 32'($urandom_range(0, 32));
        queue_item(op, pick_operand(), b);
      end
      wait (pending_items.size() == 0);
    end

    wait (pending_items.size() == 0 && !start);
    wait (expected_outcomes.size() == 0);
    repeat (W + 8) @(posedge clk);
    $display("covered %0d items over all 20 operations and unused codes, %0d results checked",
             items_sent, results_seen);
    if (error_count == 0) begin
      $display("checked_integer_alu_tb: done, clean");
    end else begin
      $display("checked_integer_alu_tb: done, errors");
    end
    $finish;
  end
endmodule
